// ===== rtl/core/rtos_task_scheduler_assert.svh =====
// Assertion macros for the task scheduler checker
`ifndef RTOS_TASK_SCHEDULER_ASSERT_SVH
`define RTOS_TASK_SCHEDULER_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define RTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Property checked in the cycle after the antecedent
`define RTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rts_pkg.sv =====
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types and constants of the task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rts_pkg;

   localparam int MaxTasks = 8;
   localparam int NumSems  = 4;
   localparam int NumSlots = MaxTasks + 1;
   localparam int SlotW    = 4;
   localparam int SemW     = 2;
   localparam logic [7:0] IdlePrioReset = 8'd100;

   typedef enum logic [3:0] {
      OP_CREATE    = 4'd0,
      OP_RUN       = 4'd1,
      OP_DELAY     = 4'd2,
      OP_TICK      = 4'd3,
      OP_SEM_NEW   = 4'd4,
      OP_PEND      = 4'd5,
      OP_POST      = 4'd6,
      OP_ISR_ENTER = 4'd7,
      OP_ISR_EXIT  = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_DELAYED = 2'd0,
      ST_READY   = 2'd1,
      ST_BLOCKED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_NO_SLOT = 2'd1,
      ERR_NO_SEM  = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_APPLY,
      FSM_SCHED,
      FSM_OUT
   } fsm_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic scan_clr;  // start a slot scan
      logic scan_step; // examine one slot
      logic apply;     // perform the operation
      logic sched_clr;
      logic sched;     // run the scheduler on the scan result
      logic out_load;  // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic need_sched;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/rts_datapath.sv =====
// ----------------------------------------------------------------------------
// rts_datapath
// Task table, semaphores, slot scan unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rts_datapath import rts_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic [3:0]        req_op,
   input  wire logic [7:0]        req_priority_req,
   input  wire logic [15:0]       req_delay_count,
   input  wire logic [1:0]        req_sem_index,
   input  wire logic signed [15:0] req_initial_value,
   input  wire cmd_type           cmd,
   output stat_type               stat,
   output logic [3:0]             rsp_running_task,
   output logic                   rsp_running_valid,
   output logic                   rsp_switched,
   output logic [31:0]            rsp_switch_count,
   output logic [3:0]             rsp_new_slot,
   output logic [1:0]             rsp_sem_handle,
   output logic [1:0]             rsp_error
);

   // table
   logic [NumSlots-1:0]      used_ff;
   logic [7:0]               prio_ff   [NumSlots];
   status_type               status_ff [NumSlots];
   logic [15:0]              delay_ff  [NumSlots];
   logic [SemW-1:0]          wsem_ff   [NumSlots];
   logic signed [15:0]       sem_ff    [NumSems];
   logic [2:0]               sems_free_ff;
   logic [SlotW-1:0]         cur_ff;
   logic                     cur_valid_ff;
   logic                     started_ff;
   logic [7:0]               isr_ff;
   logic [31:0]              sw_total_ff;
   logic [31:0]              tick_total_ff;

   // request
   op_type                   op_ff;
   logic [7:0]               prq_ff;
   logic [15:0]              dly_ff;
   logic [SemW-1:0]          sidx_ff;
   logic signed [15:0]       ival_ff;

   // scan unit: ready head, post waiter, free slot
   logic [SlotW-1:0]         idx_ff;
   logic                     head_ok_ff, wait_ok_ff, free_ok_ff;
   logic [SlotW-1:0]         head_ff, wait_ff, free_ff;
   logic [7:0]               head_p_ff, wait_p_ff;

   // operation outcome
   logic                     need_ff, sw_ff;
   logic [SlotW-1:0]         nslot_ff;
   logic [1:0]               hnd_ff;
   err_type                  err_ff;

   logic                     rdy_s, wt_s;

   assign stat.scan_done  = (idx_ff == SlotW'(NumSlots - 1));
   assign stat.need_sched = need_ff;

   always_comb begin
      rdy_s = used_ff[idx_ff] && status_ff[idx_ff] == ST_READY;
      wt_s  = used_ff[idx_ff] && status_ff[idx_ff] == ST_BLOCKED && wsem_ff[idx_ff] == sidx_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_type'(req_op);
         prq_ff  <= req_priority_req;
         dly_ff  <= req_delay_count;
         sidx_ff <= req_sem_index;
         ival_ff <= req_initial_value;
      end
      if (cmd.out_load) begin
         rsp_running_task  <= cur_ff;
         rsp_running_valid <= cur_valid_ff;
         rsp_switched      <= sw_ff;
         rsp_switch_count  <= sw_total_ff;
         rsp_new_slot      <= nslot_ff;
         rsp_sem_handle    <= hnd_ff;
         rsp_error         <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= NumSlots'(1);
         for (int s = 0; s < NumSlots; s++) begin
            prio_ff[s]   <= 8'd0;
            status_ff[s] <= ST_DELAYED;
            delay_ff[s]  <= 16'd0;
            wsem_ff[s]   <= '0;
         end
         prio_ff[0]    <= IdlePrioReset;
         status_ff[0]  <= ST_READY;
         for (int k = 0; k < NumSems; k++) sem_ff[k] <= 16'sd0;
         sems_free_ff  <= 3'(NumSems);
         cur_ff        <= '0;
         cur_valid_ff  <= 1'b0;
         started_ff    <= 1'b0;
         isr_ff        <= 8'd0;
         sw_total_ff   <= 32'd0;
         tick_total_ff <= 32'd0;
         idx_ff        <= '0;
         head_ok_ff    <= 1'b0;
         wait_ok_ff    <= 1'b0;
         free_ok_ff    <= 1'b0;
         need_ff       <= 1'b0;
         sw_ff         <= 1'b0;
      end else begin
         if (csr_we) prio_ff[0] <= csr_wdata;

         if (cmd.scan_clr) begin
            idx_ff     <= '0;
            head_ok_ff <= 1'b0;
            wait_ok_ff <= 1'b0;
            free_ok_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            if (rdy_s && (!head_ok_ff || prio_ff[idx_ff] < head_p_ff)) begin
               head_ok_ff <= 1'b1;
               head_ff    <= idx_ff;
               head_p_ff  <= prio_ff[idx_ff];
            end
            if (wt_s && (!wait_ok_ff || prio_ff[idx_ff] < wait_p_ff)) begin
               wait_ok_ff <= 1'b1;
               wait_ff    <= idx_ff;
               wait_p_ff  <= prio_ff[idx_ff];
            end
            if (!used_ff[idx_ff] && !free_ok_ff) begin
               free_ok_ff <= 1'b1;
               free_ff    <= idx_ff;
            end
            if (idx_ff != SlotW'(NumSlots - 1)) idx_ff <= idx_ff + 1'b1;
         end

         if (cmd.apply) begin
            need_ff  <= 1'b0;
            sw_ff    <= 1'b0;
            nslot_ff <= '0;
            hnd_ff   <= '0;
            err_ff   <= ERR_OK;
            unique case (op_ff)
               OP_CREATE: begin
                  if (!free_ok_ff) begin
                     err_ff <= ERR_NO_SLOT;
                  end else begin
                     used_ff[free_ff]   <= 1'b1;
                     prio_ff[free_ff]   <= prq_ff;
                     delay_ff[free_ff]  <= 16'd0;
                     status_ff[free_ff] <= ST_READY;
                     wsem_ff[free_ff]   <= '0;
                     nslot_ff           <= free_ff;
                     need_ff            <= started_ff;
                  end
               end
               OP_RUN: begin
                  started_ff <= 1'b1;
                  need_ff    <= 1'b1;
               end
               OP_DELAY: begin
                  if (dly_ff != 16'd0 && head_ok_ff) begin
                     status_ff[head_ff] <= ST_DELAYED;
                     delay_ff[head_ff]  <= dly_ff;
                     need_ff            <= started_ff;
                  end
               end
               OP_TICK: begin
                  tick_total_ff <= tick_total_ff + 32'd1;
                  for (int s = 0; s < NumSlots; s++) begin
                     if (used_ff[s] && status_ff[s] == ST_DELAYED) begin
                        if (delay_ff[s] != 16'd0) delay_ff[s] <= delay_ff[s] - 16'd1;
                        if (delay_ff[s] <= 16'd1) status_ff[s] <= ST_READY;
                     end
                  end
               end
               OP_SEM_NEW: begin
                  if (sems_free_ff == 3'd0) begin
                     err_ff <= ERR_NO_SEM;
                  end else begin
                     sems_free_ff <= sems_free_ff - 3'd1;
                     sem_ff[SemW'(sems_free_ff - 3'd1)] <= ival_ff;
                     hnd_ff <= SemW'(sems_free_ff - 3'd1);
                  end
               end
               OP_PEND: begin
                  if (sem_ff[sidx_ff] > 16'sd0) begin
                     sem_ff[sidx_ff] <= sem_ff[sidx_ff] - 16'sd1;
                  end else if (head_ok_ff) begin
                     if (sem_ff[sidx_ff] != -16'sd32768)
                        sem_ff[sidx_ff] <= sem_ff[sidx_ff] - 16'sd1;
                     status_ff[head_ff] <= ST_BLOCKED;
                     wsem_ff[head_ff]   <= sidx_ff;
                     need_ff            <= started_ff;
                  end
               end
               OP_POST: begin
                  if (sem_ff[sidx_ff] != 16'sd32767)
                     sem_ff[sidx_ff] <= sem_ff[sidx_ff] + 16'sd1;
                  if (sem_ff[sidx_ff] < 16'sd0 && wait_ok_ff) begin
                     status_ff[wait_ff] <= ST_READY;
                     need_ff <= (isr_ff == 8'd0) && started_ff;
                  end
               end
               OP_ISR_ENTER: begin
                  if (isr_ff != 8'd255) isr_ff <= isr_ff + 8'd1;
               end
               OP_ISR_EXIT: begin
                  if (isr_ff != 8'd0) begin
                     isr_ff  <= isr_ff - 8'd1;
                     need_ff <= (isr_ff == 8'd1) && started_ff;
                  end
               end
               default: ;
            endcase
         end

         // after the rescan, take the head as running task
         if (cmd.sched && head_ok_ff && !(cur_valid_ff && cur_ff == head_ff)) begin
            cur_ff       <= head_ff;
            cur_valid_ff <= 1'b1;
            sw_total_ff  <= sw_total_ff + 32'd1;
            sw_ff        <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rts_control.sv =====
// ----------------------------------------------------------------------------
// rts_control
// Sequencer: capture, scan, apply, rescan and schedule, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module rts_control import rts_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   fsm_type state_ff, state_in;
   logic    valid_ff, valid_in;
   logic    second_ff, second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   assign rsp_valid = valid_ff;

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff && !rsp_ready;
      second_in = second_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.scan_clr = 1'b1;
               second_in    = 1'b0;
               state_in     = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = second_ff ? FSM_SCHED : FSM_APPLY;
         end
         FSM_APPLY: begin
            cmd.apply    = 1'b1;
            cmd.scan_clr = 1'b1;
            second_in    = 1'b1;
            state_in     = FSM_SCAN;
         end
         FSM_SCHED: begin
            cmd.sched = stat.need_sched;
            state_in  = FSM_OUT;
         end
         FSM_OUT: begin
            // hold until the previous result is taken
            if (!valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/rtos_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// rtos_task_scheduler
// Priority-preemptive task scheduler with counting semaphores.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  op, priority, delay, sem, value
// rsp_      out        rsp_valid/rsp_ready  running task, switch, slot, error
// csr_      in         csr_we               idle priority
//
// An operation makes two sequential scans of the slot table, one slot a
// cycle. The result register lets a new request enter while a result
// waits; a stalled result holds the sequencer at its output step. Reset
// is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rtos_task_scheduler import rts_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [3:0]        req_op,
   input  wire logic [7:0]        req_priority_req,
   input  wire logic [15:0]       req_delay_count,
   input  wire logic [1:0]        req_sem_index,
   input  wire logic signed [15:0] req_initial_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [3:0]             rsp_running_task,
   output logic                   rsp_running_valid,
   output logic                   rsp_switched,
   output logic [31:0]            rsp_switch_count,
   output logic [3:0]             rsp_new_slot,
   output logic [1:0]             rsp_sem_handle,
   output logic [1:0]             rsp_error
);

   cmd_type  cmd;
   stat_type stat;

   rts_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   rts_datapath u_datapath (
      .clock, .reset, .csr_we, .csr_wdata, .req_op, .req_priority_req,
      .req_delay_count, .req_sem_index, .req_initial_value, .cmd, .stat,
      .rsp_running_task, .rsp_running_valid, .rsp_switched, .rsp_switch_count,
      .rsp_new_slot, .rsp_sem_handle, .rsp_error
   );

endmodule

`default_nettype wire

// ===== rtl/core/rts_checker.sv =====
// ----------------------------------------------------------------------------
// rts_checker
// Port-level checks of the task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtos_task_scheduler_assert.svh"

module rts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_running_valid,
   input wire logic        rsp_switched,
   input wire logic [1:0]  rsp_error,
   input wire logic [31:0] rsp_switch_count
);

   `RTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_switch_count), "result changed while stalled")
   `RTS_ASSERT_IMPL(a_switch_valid, clock, reset, rsp_valid && rsp_switched, rsp_running_valid, "switch without running task")
   `RTS_ASSERT_IMPL(a_err_code, clock, reset, rsp_valid, rsp_error != 2'd3, "undefined error code")
   `RTS_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "request taken during a transfer")

endmodule

bind rtos_task_scheduler rts_checker u_rts_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_running_valid, .rsp_switched, .rsp_error, .rsp_switch_count
);

`default_nettype wire
